### rtl/lpbc_pkg.sv
// Shared types and constants for the LED pixel bit compare encoder.
`timescale 1ns / 1ps

package lpbc_pkg;

  // Colour order codes
  localparam logic [1:0] FMT_GRB  = 2'd0;
  localparam logic [1:0] FMT_RGB  = 2'd1;
  localparam logic [1:0] FMT_GRBW = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_LED_FORMAT   = 2'd0;
  localparam logic [1:0] REG_COMPARE_ONE  = 2'd1;
  localparam logic [1:0] REG_COMPARE_ZERO = 2'd2;

  localparam int BITS_SHORT = 24;
  localparam int BITS_LONG  = 32;

  localparam int SLOT_W = 13;
  localparam int CMP_W  = 16;

  // One classified LED, ready for serialisation. The word is left aligned,
  // so the first bit to send is always bit 31.
  typedef struct packed {
    logic [31:0]       word;
    logic [SLOT_W-1:0] base;
    logic              long_fmt;
  } desc_t;

  typedef struct packed {
    logic [1:0]       led_format;
    logic [CMP_W-1:0] compare_one;
    logic [CMP_W-1:0] compare_zero;
  } cfg_t;

endpackage

### rtl/lpbc_front.sv
// Front stage: accepts colour requests, packs the colour word and works out the base slot.
`timescale 1ns / 1ps

module lpbc_front
  import lpbc_pkg::*;
#(
  parameter int LED_COUNT = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] led_index,
  input  logic [1:0] led_format,
  output logic       desc_valid,
  input  logic       desc_ready,
  output desc_t      desc
);

  logic       accept;
  logic       in_range;
  logic [7:0] min_rg;
  logic [7:0] white;
  desc_t      desc_next;

  assign full     = desc_valid && !desc_ready;
  assign accept   = push && !full;
  assign in_range = 32'(led_index) < 32'(LED_COUNT);

  assign min_rg = (red < green) ? red : green;
  assign white  = (min_rg < blue) ? min_rg : blue;

  always_comb begin
    desc_next = '0;
    unique case (led_format)
      FMT_RGB: begin
        desc_next.word     = {red, green, blue, 8'd0};
        desc_next.long_fmt = 1'b0;
        desc_next.base     = {1'b0, led_index, 4'd0} + {2'd0, led_index, 3'd0};
      end
      FMT_GRBW: begin
        desc_next.word     = {green, red, blue, white};
        desc_next.long_fmt = 1'b1;
        desc_next.base     = {led_index, 5'd0};
      end
      default: begin
        // The unused code behaves as GRB.
        desc_next.word     = {green, red, blue, 8'd0};
        desc_next.long_fmt = 1'b0;
        desc_next.base     = {1'b0, led_index, 4'd0} + {2'd0, led_index, 3'd0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
    end else begin
      desc_valid <= (accept && in_range) || (desc_valid && !desc_ready);
    end
    if (accept && in_range) begin
      desc <= desc_next;
    end
  end

endmodule

### rtl/lpbc_queue.sv
// Two-entry queue of classified LEDs between the front and back stages.
`timescale 1ns / 1ps

module lpbc_queue
  import lpbc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  desc_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output desc_t out_data
);

  desc_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];
  assign do_wr     = in_valid && in_ready;
  assign do_rd     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
    if (do_wr) begin
      entries[wr_ptr] <= in_data;
    end
  end

endmodule

### rtl/lpbc_back.sv
// Back stage: sends one compare word per bit, most significant bit first.
`timescale 1ns / 1ps

module lpbc_back
  import lpbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              desc_valid,
  output logic              desc_ready,
  input  desc_t             desc,
  input  logic [CMP_W-1:0]  compare_one,
  input  logic [CMP_W-1:0]  compare_zero,
  output logic              empty,
  input  logic              pop,
  output logic [SLOT_W-1:0] slot_index,
  output logic [CMP_W-1:0]  compare_value,
  output logic              last_bit
);

  logic              busy;
  logic              out_valid;
  logic [31:0]       shifter;
  logic [SLOT_W-1:0] base;
  logic              long_fmt;
  logic [4:0]        bit_cnt;
  logic              can_emit;
  logic              last_now;
  logic              step;

  assign empty      = !out_valid;
  assign can_emit   = !out_valid || pop;
  assign last_now   = long_fmt ? (bit_cnt == 5'(BITS_LONG - 1)) : (bit_cnt == 5'(BITS_SHORT - 1));
  assign step       = busy && can_emit;
  assign desc_ready = !busy || (step && last_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      bit_cnt   <= 5'd0;
    end else begin
      if (can_emit) begin
        out_valid <= busy;
      end
      if (step) begin
        bit_cnt <= bit_cnt + 5'd1;
      end
      if (desc_valid && desc_ready) begin
        busy    <= 1'b1;
        bit_cnt <= 5'd0;
      end else if (step && last_now) begin
        busy <= 1'b0;
      end
    end
    if (step) begin
      slot_index    <= base + {{(SLOT_W - 5){1'b0}}, bit_cnt};
      compare_value <= shifter[31] ? compare_one : compare_zero;
      last_bit      <= last_now;
      shifter       <= {shifter[30:0], 1'b0};
    end
    if (desc_valid && desc_ready) begin
      shifter  <= desc.word;
      base     <= desc.base;
      long_fmt <= desc.long_fmt;
    end
  end

endmodule

### rtl/led_pixel_bit_compare_encoder_unit.sv
// Top level of the LED pixel bit compare encoder: configuration registers and the three stages.
`timescale 1ns / 1ps

// Channel        Signals                                   Request moves when
// -------------  ----------------------------------------  --------------------------
// colour in      push, full, red, green, blue, led_index   push high and full low
// bit words out  empty, pop, slot_index, compare_value,    pop high and empty low
//                last_bit
// configuration  cfg_write, cfg_index, cfg_data            cfg_write high
//
// Each colour request for an LED on the strip yields 24 words (GRB, RGB)
// or 32 words (GRBW), one per cycle from the back stage's bit counter while
// pop keeps the output drained; the next request loads as the last word is
// sent. A request passes the front register, the queue and the back shifter
// before its first word is registered out. Reset is synchronous and clears
// all control state and the registers. A stalled output holds the back stage
// only; the front stage and the two-entry queue take requests until full.

module led_pixel_bit_compare_encoder_unit
  import lpbc_pkg::*;
#(
  parameter int LED_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic [7:0]        led_index,
  output logic              empty,
  input  logic              pop,
  output logic [SLOT_W-1:0] slot_index,
  output logic [CMP_W-1:0]  compare_value,
  output logic              last_bit,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [CMP_W-1:0]  cfg_data
);

  cfg_t  cfg;
  logic  front_valid;
  logic  front_ready;
  desc_t front_desc;
  logic  q_valid;
  logic  q_ready;
  desc_t q_desc;

  // Configuration registers. A write to the unused index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LED_FORMAT:   cfg.led_format   <= cfg_data[1:0];
        REG_COMPARE_ONE:  cfg.compare_one  <= cfg_data;
        REG_COMPARE_ZERO: cfg.compare_zero <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front stage drops requests for LEDs beyond the strip, so they
  // produce no words at all.
  lpbc_front #(
    .LED_COUNT (LED_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .led_index  (led_index),
    .led_format (cfg.led_format),
    .desc_valid (front_valid),
    .desc_ready (front_ready),
    .desc       (front_desc)
  );

  lpbc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_desc),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_desc)
  );

  // The back stage loads the next LED in the cycle that sends the last word
  // of the current one, so words follow without a gap.
  lpbc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .desc_valid    (q_valid),
    .desc_ready    (q_ready),
    .desc          (q_desc),
    .compare_one   (cfg.compare_one),
    .compare_zero  (cfg.compare_zero),
    .empty         (empty),
    .pop           (pop),
    .slot_index    (slot_index),
    .compare_value (compare_value),
    .last_bit      (last_bit)
  );

endmodule

### tb/testbench.sv
// Self-checking testbench for the LED pixel bit compare encoder unit.
`timescale 1ns / 1ps

module testbench;
  import lpbc_pkg::*;

  localparam int LED_COUNT    = 256;
  // Idle cycles the driver waits for before a register write or a settle point.
  localparam int QUIET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  // The colour order code and the register index that the unit leaves undefined.
  localparam logic [1:0] FMT_SPARE = 2'd3;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {ENTRY_PIXEL, ENTRY_CFG, ENTRY_SETTLE, ENTRY_MODE} entry_kind_t;

  // One step of the stimulus: a colour request, a register write, a pause until
  // the unit has drained, or a change of the idling mix.
  typedef struct {
    entry_kind_t      kind;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       led;
    logic [1:0]       reg_idx;
    logic [CMP_W-1:0] data;
    int               send_idle;
    int               recv_idle;
  } led_request_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [CMP_W-1:0]  value;
    logic              last;
  } bit_word_t;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              push          = 1'b0;
  logic              full;
  logic [7:0]        red           = 8'h00;
  logic [7:0]        green         = 8'h00;
  logic [7:0]        blue          = 8'h00;
  logic [7:0]        led_index     = 8'h00;
  logic              empty;
  logic              pop           = 1'b0;
  logic [SLOT_W-1:0] slot_index;
  logic [CMP_W-1:0]  compare_value;
  logic              last_bit;
  logic              cfg_write     = 1'b0;
  logic [1:0]        cfg_index     = REG_LED_FORMAT;
  logic [CMP_W-1:0]  cfg_data      = '0;

  led_pixel_bit_compare_encoder_unit #(.LED_COUNT(LED_COUNT)) uut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .led_index     (led_index),
    .empty         (empty),
    .pop           (pop),
    .slot_index    (slot_index),
    .compare_value (compare_value),
    .last_bit      (last_bit),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Stimulus still to be driven, and the bit words the unit still owes us.
  led_request_t led_requests[$];
  bit_word_t    pending_words[$];

  // Our own copy of the three registers, updated when a write is accepted.
  logic [1:0]       fmt_reg  = FMT_GRB;
  logic [CMP_W-1:0] one_reg  = '0;
  logic [CMP_W-1:0] zero_reg = '0;

  int send_idle    = 0;
  int recv_idle    = 0;
  int issued_cnt   = 0;
  int accepted_cnt = 0;
  int quiet_run    = 0;
  int failures     = 0;
  int words_checked = 0;
  int cfg_writes   = 0;
  int settle_points = 0;
  int leds_by_format[4] = '{0, 0, 0, 0};

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Packs the colour by the current order and queues one compare word per bit,
  // most significant bit first. In the four-channel order white is the smallest
  // of the three channels. The unused order code falls back to GRB. An LED past
  // the end of the strip produces nothing at all.
  function automatic void predict_led_words(input logic [7:0] r, g, b, led);
    logic [31:0] colour_word;
    logic [7:0]  white;
    int          nbits;
    int          slot;
    bit_word_t   w;
    if (int'(led) >= LED_COUNT) return;
    white = (r < g) ? r : g;
    if (b < white) white = b;
    case (fmt_reg)
      FMT_RGB: begin
        colour_word = {8'h00, r, g, b};
        nbits = BITS_SHORT;
      end
      FMT_GRBW: begin
        colour_word = {g, r, b, white};
        nbits = BITS_LONG;
      end
      default: begin
        colour_word = {8'h00, g, r, b};
        nbits = BITS_SHORT;
      end
    endcase
    for (int k = 0; k < nbits; k++) begin
      slot = int'(led) * nbits + k;
      w.slot = slot[SLOT_W-1:0];
      w.value = colour_word[nbits-1-k] ? one_reg : zero_reg;
      w.last = (k == nbits - 1);
      pending_words.push_back(w);
    end
    leds_by_format[fmt_reg]++;
  endfunction

  // Driver: every input changes on the falling edge. Each signal gets a single
  // nonblocking update per edge, so push stays high across back-to-back requests.
  always @(negedge clk) begin
    led_request_t head;
    logic next_push;
    logic next_write;
    next_push = 1'b0;
    next_write = 1'b0;
    if (!rst) begin
      if (pending_words.size() == 0 && !push && !cfg_write) begin
        quiet_run++;
      end else begin
        quiet_run = 0;
      end
      if (push && accepted_cnt != issued_cnt) begin
        // The request on the port has not been taken yet; hold it.
        next_push = 1'b1;
      end else if (led_requests.size() != 0) begin
        head = led_requests[0];
        case (head.kind)
          ENTRY_PIXEL: begin
            if ($urandom_range(99) >= send_idle) begin
              led_requests.delete(0);
              red <= head.red;
              green <= head.green;
              blue <= head.blue;
              led_index <= head.led;
              next_push = 1'b1;
              issued_cnt++;
            end
          end
          ENTRY_MODE: begin
            led_requests.delete(0);
            send_idle = head.send_idle;
            recv_idle = head.recv_idle;
          end
          ENTRY_SETTLE: begin
            if (quiet_run >= QUIET_CYCLES) begin
              led_requests.delete(0);
              settle_points++;
            end
          end
          ENTRY_CFG: begin
            // Registers only change while the unit is fully drained.
            if (quiet_run >= QUIET_CYCLES) begin
              led_requests.delete(0);
              cfg_index <= head.reg_idx;
              cfg_data <= head.data;
              next_write = 1'b1;
            end
          end
          default: ;
        endcase
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end else begin
      pop <= 1'b0;
    end
    push <= next_push;
    cfg_write <= next_write;
  end

  // Monitor: samples on the rising edge, before the unit's own updates land.
  always @(posedge clk) begin
    bit_word_t got;
    bit_word_t want;
    if (rst) begin
      fmt_reg = FMT_GRB;
      one_reg = '0;
      zero_reg = '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_LED_FORMAT:   fmt_reg = cfg_data[1:0];
          REG_COMPARE_ONE:  one_reg = cfg_data;
          REG_COMPARE_ZERO: zero_reg = cfg_data;
          default: ;
        endcase
        cfg_writes++;
      end
      if (pop && !empty) begin
        got.slot = slot_index;
        got.value = compare_value;
        got.last = last_bit;
        if (pending_words.size() == 0) begin
          note_failure($sformatf("unexpected word: slot %0d value %h last %b",
                                 got.slot, got.value, got.last));
        end else begin
          want = pending_words.pop_front();
          words_checked++;
          if (got.slot !== want.slot || got.value !== want.value
              || got.last !== want.last) begin
            note_failure($sformatf(
              "word mismatch: slot %0d/%0d value %h/%h last %b/%b (expected/actual)",
              want.slot, got.slot, want.value, got.value, want.last, got.last));
          end
        end
      end
      if (push && !full) begin
        predict_led_words(red, green, blue, led_index);
        accepted_cnt++;
      end
    end
  end

  task automatic add_led(input logic [7:0] r, g, b, led);
    led_request_t e;
    e.kind = ENTRY_PIXEL;
    e.red = r;
    e.green = g;
    e.blue = b;
    e.led = led;
    led_requests.push_back(e);
  endtask

  task automatic add_reg(input logic [1:0] idx, input logic [CMP_W-1:0] data);
    led_request_t e;
    e.kind = ENTRY_CFG;
    e.reg_idx = idx;
    e.data = data;
    led_requests.push_back(e);
  endtask

  task automatic add_mode(input int send_pct, input int recv_pct);
    led_request_t e;
    e.kind = ENTRY_MODE;
    e.send_idle = send_pct;
    e.recv_idle = recv_pct;
    led_requests.push_back(e);
  endtask

  task automatic add_settle();
    led_request_t e;
    e.kind = ENTRY_SETTLE;
    led_requests.push_back(e);
  endtask

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [CMP_W-1:0] rand_compare();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return CMP_W'($urandom());
    endcase
  endfunction

  task automatic add_random_leds(input int count);
    logic [7:0] r, g, b, led;
    for (int i = 0; i < count; i++) begin
      r = rand_channel();
      g = rand_channel();
      b = rand_channel();
      // Equal channels now and then, so the white minimum sees ties.
      if ($urandom_range(9) == 0) begin
        g = r;
        b = r;
      end
      if ($urandom_range(9) == 0) begin
        led = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
      end else begin
        led = 8'($urandom_range(255));
      end
      add_led(r, g, b, led);
    end
  endtask

  // One idling mix: three register settings, each with a burst of colours
  // and a pause in the middle where the sender waits for the unit to drain.
  task automatic run_phase(input int send_pct, input int recv_pct);
    add_mode(send_pct, recv_pct);
    for (int blk = 0; blk < 3; blk++) begin
      // Random write data: the format lands on any of the four codes.
      add_reg(REG_LED_FORMAT, CMP_W'($urandom()));
      add_reg(REG_COMPARE_ONE, rand_compare());
      add_reg(REG_COMPARE_ZERO, rand_compare());
      add_random_leds(15);
      add_settle();
      add_random_leds(16);
    end
  endtask

  initial begin
    // Directed part, under the first idling mix.
    add_mode(11, 86);
    // Registers still at their reset values: every word is zero.
    add_led(8'hA5, 8'h3C, 8'h0F, 8'd0);

    add_reg(REG_COMPARE_ONE, 16'hFFFF);
    add_reg(REG_COMPARE_ZERO, 16'h0000);
    add_reg(REG_LED_FORMAT, {14'h0000, FMT_GRB});
    add_led(8'h00, 8'h00, 8'h00, 8'd0);
    add_led(8'hFF, 8'hFF, 8'hFF, 8'd255);
    add_led(8'h80, 8'h01, 8'h7F, 8'd128);
    add_led(8'h01, 8'h80, 8'hFE, 8'd1);

    add_reg(REG_LED_FORMAT, {14'h0000, FMT_RGB});
    add_reg(REG_COMPARE_ONE, 16'h1234);
    add_reg(REG_COMPARE_ZERO, 16'hABCD);
    add_led(8'hFF, 8'h00, 8'h00, 8'd255);
    add_led(8'h00, 8'hFF, 8'h00, 8'd7);
    add_led(8'h00, 8'h00, 8'hFF, 8'd64);
    add_led(8'h55, 8'hAA, 8'hC3, 8'd200);

    // Four-channel order; the upper data bits must be dropped by the format
    // register. The last slot of the strip reaches the top of the slot range.
    add_reg(REG_LED_FORMAT, {14'h3FFF, FMT_GRBW});
    add_reg(REG_COMPARE_ONE, 16'h0000);
    add_reg(REG_COMPARE_ZERO, 16'hFFFF);
    add_led(8'hFF, 8'hFF, 8'hFF, 8'd255);
    add_led(8'h10, 8'h20, 8'h30, 8'd3);
    add_led(8'h40, 8'h05, 8'h60, 8'd4);
    add_led(8'h70, 8'h80, 8'h09, 8'd5);
    add_led(8'h22, 8'h22, 8'h22, 8'd6);
    add_led(8'h00, 8'h00, 8'h00, 8'd0);

    // The unused order code behaves as GRB.
    add_reg(REG_LED_FORMAT, {14'h0000, FMT_SPARE});
    add_led(8'hC0, 8'h3F, 8'h81, 8'd254);
    add_led(8'hFF, 8'hFF, 8'hFF, 8'd255);

    // A write to the spare index changes nothing.
    add_reg(REG_SPARE, 16'hFFFE);
    add_led(8'h12, 8'h34, 8'h56, 8'd100);

    // Random part: the sender mostly busy while the receiver stalls, then the
    // reverse, then neither side idles.
    run_phase(11, 86);
    run_phase(86, 11);
    run_phase(0, 0);

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (led_requests.size() != 0 || push || pending_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) begin
      note_failure($sformatf("%0d bit words never arrived", pending_words.size()));
    end

    $display("Covered %0d LEDs (GRB %0d, RGB %0d, GRBW %0d, spare code %0d), %0d words",
             accepted_cnt, leds_by_format[0], leds_by_format[1], leds_by_format[2],
             leds_by_format[3], words_checked);
    $display("%0d register writes, %0d drain pauses, three idling mixes, %0d failures",
             cfg_writes, settle_points, failures);
    if (failures == 0) begin
      $display("led_pixel_bit_compare_encoder_unit test passed");
    end else begin
      $display("led_pixel_bit_compare_encoder_unit test failed");
    end
    $finish;
  end

  // Watchdog: a correct run finishes in well under a tenth of this time.
  initial begin
    #4_000_000;
    $display("Timeout with %0d requests and %0d words outstanding",
             led_requests.size(), pending_words.size());
    $display("led_pixel_bit_compare_encoder_unit test failed");
    $finish;
  end

endmodule

### led_pixel_bit_compare_encoder_unit.f
rtl/lpbc_pkg.sv
rtl/lpbc_front.sv
rtl/lpbc_queue.sv
rtl/lpbc_back.sv
rtl/led_pixel_bit_compare_encoder_unit.sv
tb/testbench.sv
